### sv/cftd_pkg.sv
// cftd_pkg: shared types and constants of the can frame telemetry decoder
// signal codes, frame identifiers and the result/update structs
// no dependencies
package cftd_pkg;

	localparam int NUM_SLOTS = 4;

	typedef enum logic [3:0] {
		SIG_VOLT     = 4'd0,
		SIG_AMP      = 4'd1,
		SIG_POWER    = 4'd2,
		SIG_DCDC     = 4'd3,
		SIG_REGEN    = 4'd4,
		SIG_DRIVE    = 4'd5,
		SIG_MOTOR    = 4'd6,
		SIG_BATT     = 4'd7,
		SIG_CHARGER  = 4'd8,
		SIG_INVERTER = 4'd9,
		SIG_SOC      = 4'd10,
		SIG_SOH      = 4'd11,
		SIG_RPM      = 4'd12,
		SIG_SPEED    = 4'd13
	} sig_code_t;

	localparam logic [10:0] ID_BMS_LIMITS = 11'h424;
	localparam logic [10:0] ID_BMS_STATE  = 11'h155;
	localparam logic [10:0] ID_MOTOR_TEMP = 11'h196;
	localparam logic [10:0] ID_CHARGER    = 11'h597;
	localparam logic [10:0] ID_INVERTER   = 11'h59E;
	localparam logic [10:0] ID_PACK_VOLT  = 11'h55F;
	localparam logic [10:0] ID_MOTOR_RPM  = 11'h19F;

	// slot that carries the divided value (power or speed)
	localparam logic [1:0] DIV_SLOT = 2'd1;

	// result count of a frame with an unknown id
	localparam logic [2:0] COUNT_NONE = 3'd0;
	localparam logic [7:0] FULL_SCALE_DEFAULT = 8'd84;

	typedef struct packed {
		logic [2:0]                  count;
		logic [NUM_SLOTS-1:0][3:0]   code;
		logic [NUM_SLOTS-1:0][22:0]  value;
		logic                        div_used;
		logic                        div_speed;
		logic                        div_neg;
		logic [30:0]                 div_mag;
	} res_t;

	typedef struct packed {
		logic        volt_we;
		logic [15:0] volt_new;
		logic        cur_we;
		logic [16:0] cur_new;
	} upd_t;

endpackage

### sv/can_frame_telemetry_decoder_unit.sv
// can_frame_telemetry_decoder_unit: top level of the can frame telemetry decoder
// input register, decode stage with pack voltage/current state, result buffer
// depends on cftd_pkg, cftd_decode, cftd_result_buf
//
// channel      | direction | contents
// s_axis_*     | in        | frame_id[10:0], payload[74:11]
// m_axis_*     | out       | signal_code[3:0], signal_value[26:4], tlast = last_of_frame
// cfg_wr_*     | in        | full_scale_speed, written whenever cfg_wr_en is high
//
// a frame passes the input register, decode stage and result buffer, then its
// results leave the single output port one per cycle while m_axis_tready is high;
// at most four per frame, the next frame loading as the last is taken; unknown ids
// give no results. reset clears valid flags, pack voltage/current, sets full scale to 84
// an output stall backs up through the result buffer, decode stage and input register
module can_frame_telemetry_decoder_unit import cftd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // frame_id[10:0], payload[74:11], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // signal_code[3:0], signal_value[26:4], zero pad
	output logic        m_axis_tlast,  // last_of_frame
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	logic        valid_s1;
	logic [10:0] frame_id_s1;
	logic [63:0] payload_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res_dec;
	upd_t        upd_dec;
	logic [15:0] volt_q;
	logic [16:0] amp_q;
	logic [7:0]  full_scale_q;
	logic        s3_free;
	logic        s2_free;
	logic        adv_s1;
	logic        adv_s2;

	assign adv_s2        = valid_s2 && s3_free;
	assign s2_free       = !valid_s2 || adv_s2;
	assign adv_s1        = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_DEFAULT;
		end else if (cfg_wr_en) begin
			full_scale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			volt_q   <= '0;
			amp_q    <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= adv_s1 && (res_dec.count != COUNT_NONE);
			end
			if (adv_s1 && upd_dec.volt_we) begin
				volt_q <= upd_dec.volt_new;
			end
			if (adv_s1 && upd_dec.cur_we) begin
				amp_q <= upd_dec.cur_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			frame_id_s1 <= s_axis_tdata[10:0];
			payload_s1  <= s_axis_tdata[74:11];
		end
		if (adv_s1) begin
			res_s2 <= res_dec;
		end
	end

	cftd_decode u_decode (
		.frame_id   (frame_id_s1),
		.payload    (payload_s1),
		.full_scale (full_scale_q),
		.volt_cur   (volt_q),
		.amp_cur    (amp_q),
		.res        (res_dec),
		.upd        (upd_dec)
	);

	cftd_result_buf u_result_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv_s2),
		.res           (res_s2),
		.free          (s3_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_s2_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.count != COUNT_NONE))
		else $error("decode stage holds a frame without results");

	a_next_frame_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && valid_s2) |=> m_axis_tvalid)
		else $error("pending frame not moved into the result buffer");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(volt_q) && $stable(amp_q)))
		else $error("pack state changed without a decoded frame");

endmodule

### sv/cftd_decode.sv
// cftd_decode: combinational decode of one frame into up to four results
// also yields the pack voltage/current updates and the operand for the divider
// depends on cftd_pkg
module cftd_decode import cftd_pkg::*; (
	input  logic [10:0] frame_id,
	input  logic [63:0] payload,
	input  logic [7:0]  full_scale,
	input  logic [15:0] volt_cur,
	input  logic [16:0] amp_cur,
	output res_t        res,
	output upd_t        upd
);

	function automatic logic signed [22:0] off40_x100(input logic [7:0] b);
		logic signed [8:0] d;
		d = $signed({1'b0, b}) - 9'sd40;
		return $signed({{14{d[8]}}, d}) * 23'sd100;
	endfunction

	logic [7:0]         b1, b2, b3, b4, b5, b6, b7;
	logic [11:0]        t_amp, t_volt;
	logic signed [17:0] amp18;
	logic [15:0]        volt_new;
	logic signed [12:0] t_rpm;
	logic [11:0]        t_rpm_abs;
	logic [15:0]        volt_use;
	logic [16:0]        amp_use;
	logic [15:0]        amp_abs;
	logic               is_speed;
	logic [15:0]        mul_a, mul_b;
	logic [31:0]        prod;
	logic [8:0]         batt_sum;

	assign b1 = payload[55:48];
	assign b2 = payload[47:40];
	assign b3 = payload[39:32];
	assign b4 = payload[31:24];
	assign b5 = payload[23:16];
	assign b6 = payload[15:8];
	assign b7 = payload[7:0];

	assign t_amp    = {b1[3:0], b2};
	assign t_volt   = {b6[3:0], b7};
	assign amp18    = 18'sd50000 - $signed({1'b0, 17'(t_amp) * 17'd25});
	assign volt_new = 16'(t_volt) * 16'd10;
	assign t_rpm    = $signed({1'b0, b2, b3[7:4]}) - 13'sd2000;
	assign t_rpm_abs = t_rpm[12] ? 12'(-t_rpm) : 12'(t_rpm);
	assign batt_sum = 9'(b4) + 9'(b7);

	assign volt_use = (frame_id == ID_PACK_VOLT) ? volt_new : volt_cur;
	assign amp_use  = (frame_id == ID_BMS_STATE) ? amp18[16:0] : amp_cur;
	assign amp_abs  = amp_use[16] ? 16'(-amp_use) : amp_use[15:0];

	// one multiplier shared by power and speed
	assign is_speed = (frame_id == ID_MOTOR_RPM);
	assign mul_a    = is_speed ? {4'd0, t_rpm_abs} : volt_use;
	assign mul_b    = is_speed ? {8'd0, full_scale} : amp_abs;
	assign prod     = 32'(mul_a) * 32'(mul_b);

	always_comb begin
		res           = '0;
		res.div_speed = is_speed;
		res.div_neg   = is_speed ? t_rpm[12] : amp_use[16];
		res.div_mag   = is_speed ? {prod[28:0], 2'b00} : prod[30:0];
		upd           = '0;
		upd.volt_new  = volt_new;
		upd.cur_new   = amp18[16:0];
		unique case (frame_id)
			ID_BMS_LIMITS: begin
				res.count    = 3'd4;
				res.code[0]  = SIG_REGEN;
				res.value[0] = -$signed({9'd0, 14'(b2) * 14'd50});
				res.code[1]  = SIG_DRIVE;
				res.value[1] = {9'd0, 14'(b3) * 14'd50};
				res.code[2]  = SIG_BATT;
				res.value[2] = off40_x100(batt_sum[8:1]);
				res.code[3]  = SIG_SOH;
				res.value[3] = {8'd0, 15'(b5) * 15'd100};
			end
			ID_BMS_STATE: begin
				res.count    = 3'd3;
				res.code[0]  = SIG_AMP;
				res.value[0] = $signed({{6{amp18[16]}}, amp18[16:0]});
				res.code[1]  = SIG_POWER;
				res.div_used = 1'b1;
				res.code[2]  = SIG_SOC;
				res.value[2] = {9'd0, b4, b5[7:2]};
				upd.cur_we   = 1'b1;
			end
			ID_MOTOR_TEMP: begin
				res.count    = 3'd1;
				res.code[0]  = SIG_MOTOR;
				res.value[0] = off40_x100(b5);
			end
			ID_CHARGER: begin
				res.count    = 3'd2;
				res.code[0]  = SIG_CHARGER;
				res.value[0] = off40_x100(b7);
				res.code[1]  = SIG_DCDC;
				res.value[1] = {7'd0, 16'(b2) * 16'd240};
			end
			ID_INVERTER: begin
				res.count    = 3'd1;
				res.code[0]  = SIG_INVERTER;
				res.value[0] = off40_x100(b5);
			end
			ID_PACK_VOLT: begin
				res.count    = 3'd2;
				res.code[0]  = SIG_VOLT;
				res.value[0] = {7'd0, volt_new};
				res.code[1]  = SIG_POWER;
				res.div_used = 1'b1;
				upd.volt_we  = 1'b1;
			end
			ID_MOTOR_RPM: begin
				res.count    = 3'd2;
				res.code[0]  = SIG_RPM;
				res.value[0] = $signed({{10{t_rpm[12]}}, t_rpm}) * 23'sd1000;
				res.code[1]  = SIG_SPEED;
				res.div_used = 1'b1;
			end
			default: begin
				res.count = 3'd0;
			end
		endcase
	end

endmodule

### sv/cftd_result_buf.sv
// cftd_result_buf: result register bank, constant divider and output sequencer
// divides by 100000 or 29 through a reciprocal multiply, then sends one result a cycle while m_axis_tready is high
// depends on cftd_pkg
module cftd_result_buf import cftd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // signal_code[3:0], signal_value[26:4], zero pad
	output logic        m_axis_tlast   // last_of_frame
);

	// floor(x/100000) = (x*M)>>48 for x < 2^31, floor(x/29) = (x*M)>>32 for x < 2^22
	localparam logic [31:0] RECIP_POWER = 32'd2814749768;
	localparam logic [31:0] RECIP_SPEED = 32'd148102321;

	logic [NUM_SLOTS-1:0][3:0]  code_s3;
	logic [NUM_SLOTS-1:0][22:0] value_s3;
	logic [2:0]                 count_s3;
	logic [1:0]                 ptr_s3;
	logic                       valid_s3;
	logic [63:0]                quot_prod;
	logic [16:0]                quot;
	logic [22:0]                quot_signed;
	logic [NUM_SLOTS-1:0][22:0] value_load;
	logic                       last;

	assign quot_prod   = 64'(res.div_mag) * 64'(res.div_speed ? RECIP_SPEED : RECIP_POWER);
	assign quot        = res.div_speed ? quot_prod[48:32] : {2'b00, quot_prod[62:48]};
	assign quot_signed = res.div_neg ? 23'(-{6'd0, quot}) : {6'd0, quot};

	always_comb begin
		value_load = res.value;
		if (res.div_used) begin
			value_load[DIV_SLOT] = quot_signed;
		end
	end

	assign last = ({1'b0, ptr_s3} == (count_s3 - 3'd1));
	assign free = !valid_s3 || (m_axis_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			ptr_s3   <= 2'd0;
		end else if (load) begin
			valid_s3 <= 1'b1;
			ptr_s3   <= 2'd0;
		end else if (valid_s3 && m_axis_tready) begin
			if (last) begin
				valid_s3 <= 1'b0;
			end else begin
				ptr_s3 <= ptr_s3 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s3  <= res.code;
			value_s3 <= value_load;
			count_s3 <= res.count;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {5'd0, value_s3[ptr_s3], code_s3[ptr_s3]};
	assign m_axis_tlast  = last;

endmodule

### test/can_frame_telemetry_decoder_unit_tb.sv
// can_frame_telemetry_decoder_unit_tb: self-checking bench for the telemetry decoder
// frames are sent, every decoded signal is predicted and compared field by field
// depends on cftd_pkg and can_frame_telemetry_decoder_unit
module can_frame_telemetry_decoder_unit_tb;
	import cftd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [10:0] id;
		logic [63:0] payload;
	} can_frame_t;

	typedef struct {
		logic [3:0]  code;
		logic [22:0] value;
		logic        last;
	} telemetry_signal_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	can_frame_t        pending_frames[$];
	can_frame_t        offered_frame;
	telemetry_signal_t expected_signals[$];
	telemetry_signal_t got_signal;

	logic [7:0]  full_scale_model = FULL_SCALE_DEFAULT;
	logic [15:0] volt_model = '0;
	int          current_model = 0;

	logic quiet = 1'b0;
	logic hold_phase = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;
	int   mismatches = 0;
	int   frames_sent = 0;
	int   signals_checked = 0;
	int   cycle_count = 0;

	can_frame_telemetry_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic void add_signal(input sig_code_t code, input longint val);
		telemetry_signal_t s;
		s.code = code;
		s.value = val[22:0];
		s.last = 1'b0;
		expected_signals.push_back(s);
	endfunction

	function automatic longint pack_power();
		return (longint'(volt_model) * longint'(current_model)) / 100000;
	endfunction

	function automatic void decode_frame(input logic [10:0] id, input logic [63:0] pl);
		int b[8];
		int t;
		int n;
		n = expected_signals.size();
		for (int i = 0; i < 8; i++) b[i] = int'(pl[63-8*i -: 8]);
		case (id)
			ID_BMS_LIMITS: begin
				add_signal(SIG_REGEN, -b[2] * 50);
				add_signal(SIG_DRIVE, b[3] * 50);
				add_signal(SIG_BATT, ((b[4] + b[7]) / 2 - 40) * 100);
				add_signal(SIG_SOH, b[5] * 100);
			end
			ID_BMS_STATE: begin
				t = (b[1] & 15) * 256 + b[2];
				current_model = 50000 - 25 * t;
				add_signal(SIG_AMP, current_model);
				add_signal(SIG_POWER, pack_power());
				add_signal(SIG_SOC, (b[4] * 256 + b[5]) / 4);
			end
			ID_MOTOR_TEMP: add_signal(SIG_MOTOR, (b[5] - 40) * 100);
			ID_CHARGER: begin
				add_signal(SIG_CHARGER, (b[7] - 40) * 100);
				add_signal(SIG_DCDC, b[2] * 240);
			end
			ID_INVERTER: add_signal(SIG_INVERTER, (b[5] - 40) * 100);
			ID_PACK_VOLT: begin
				t = (b[6] & 15) * 256 + b[7];
				volt_model = 16'(t * 10);
				add_signal(SIG_VOLT, volt_model);
				add_signal(SIG_POWER, pack_power());
			end
			ID_MOTOR_RPM: begin
				t = b[2] * 16 + (b[3] >> 4) - 2000;
				add_signal(SIG_RPM, t * 1000);
				add_signal(SIG_SPEED, (longint'(t) * longint'(full_scale_model) * 4) / 29);
			end
			default: ;
		endcase
		if (expected_signals.size() > n)
			expected_signals[expected_signals.size()-1].last = 1'b1;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_frame(offered_frame.id, offered_frame.payload);
				frames_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_frames.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
					offered_frame = pending_frames.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, offered_frame.payload, offered_frame.id};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_signals.size() == 0) begin
					report_mismatch($sformatf("unexpected signal code %0d value %h",
						m_axis_tdata[3:0], m_axis_tdata[26:4]));
				end else begin
					got_signal = expected_signals.pop_front();
					signals_checked++;
					if (m_axis_tdata[3:0] !== got_signal.code)
						report_mismatch($sformatf("code got %0d exp %0d",
							m_axis_tdata[3:0], got_signal.code));
					if (m_axis_tdata[26:4] !== got_signal.value)
						report_mismatch($sformatf("code %0d value got %0d exp %0d",
							got_signal.code, $signed(m_axis_tdata[26:4]),
							$signed(got_signal.value)));
					if (m_axis_tlast !== got_signal.last)
						report_mismatch($sformatf("code %0d tlast got %b exp %b",
							got_signal.code, m_axis_tlast, got_signal.last));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_phase && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || $urandom_range(99) >= 10;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_frame(input logic [10:0] id, input logic [63:0] pl);
		can_frame_t f;
		f.id = id;
		f.payload = pl;
		pending_frames.push_back(f);
	endtask

	function automatic logic [10:0] pick_known_id(input int k);
		case (k)
			0: return ID_BMS_LIMITS;
			1: return ID_BMS_STATE;
			2: return ID_MOTOR_TEMP;
			3: return ID_CHARGER;
			4: return ID_INVERTER;
			5: return ID_PACK_VOLT;
			default: return ID_MOTOR_RPM;
		endcase
	endfunction

	task automatic send_random_frames(input int count);
		logic [10:0] id;
		logic [63:0] pl;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 85) id = pick_known_id($urandom_range(6));
			else id = 11'($urandom);
			case ($urandom_range(19))
				0: pl = '0;
				1: pl = '1;
				2: pl = {8{8'($urandom)}};
				default: pl = {$urandom, $urandom};
			endcase
			send_frame(id, pl);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_frames.size() > 0 || s_axis_tvalid || expected_signals.size() > 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_full_scale(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		full_scale_model = v;
		@(negedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		@(negedge clk);

		// reset state: zero pack voltage/current and default full scale
		send_frame(ID_BMS_STATE, 64'h0000_0000_0000_0000);
		send_frame(ID_MOTOR_RPM, 64'h0000_FFF0_0000_0000);
		send_frame(ID_MOTOR_RPM, 64'h0000_0000_0000_0000);
		send_frame(ID_MOTOR_RPM, 64'h0000_7D00_0000_0000);
		send_frame(ID_BMS_LIMITS, 64'h0000_0000_0000_0000);
		send_frame(ID_BMS_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_MOTOR_TEMP, 64'h0000_0000_0000_0000);
		send_frame(ID_MOTOR_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_CHARGER, 64'h0000_0000_0000_0000);
		send_frame(ID_CHARGER, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_INVERTER, 64'h0000_0000_0000_0000);
		send_frame(ID_INVERTER, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_PACK_VOLT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_BMS_STATE, 64'h000F_FF00_FFFF_0000);
		send_frame(ID_BMS_STATE, 64'h0000_0000_0000_0000);
		send_frame(ID_BMS_STATE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_PACK_VOLT, 64'h0000_0000_0000_0000);
		send_frame(ID_PACK_VOLT, 64'h0000_0000_0000_0F0A);
		// unknown ids leave the state alone
		send_frame(11'h000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(11'h7FF, 64'h0000_0000_0000_0000);
		send_frame(11'h425, 64'hA5A5_A5A5_A5A5_A5A5);
		send_frame(ID_BMS_STATE, 64'h0007_D000_1234_0000);
		wait_drained();

		write_full_scale(8'd1);
		send_random_frames(50);
		hold_phase = 1'b1;
		wait_drained();

		write_full_scale(8'd255);
		quiet = 1'b1;
		send_random_frames(60);
		wait_drained();
		quiet = 1'b0;

		// zero full scale forces speed to zero
		write_full_scale(8'd0);
		send_frame(ID_MOTOR_RPM, 64'h0000_FFF0_0000_0000);
		send_frame(ID_MOTOR_RPM, 64'h0000_0000_0000_0000);
		send_random_frames(40);
		wait_drained();

		write_full_scale(8'($urandom_range(255, 1)));
		send_random_frames(80);
		wait_drained();

		if (expected_signals.size() > 0)
			report_mismatch($sformatf("%0d signals never arrived", expected_signals.size()));
		$display("sent %0d frames, checked %0d decoded signals", frames_sent, signals_checked);
		$display("full scale speed 84, 1, 255, 0 and %0d, with a %0d cycle output hold",
			full_scale_model, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
sv/cftd_pkg.sv
sv/cftd_decode.sv
sv/cftd_result_buf.sv
sv/can_frame_telemetry_decoder_unit.sv
test/can_frame_telemetry_decoder_unit_tb.sv
